// ===== hdl/ctgp_pkg.sv =====
`default_nettype none

package ctgp_pkg;

  // parse limits
  localparam int MAX_TILDES   = 15;
  localparam int TILDE_W      = (MAX_TILDES > 0) ? $clog2(MAX_TILDES + 1) : 1;
  localparam int SYMBOL_COUNT = 83;
  localparam int SYM_W        = $clog2(SYMBOL_COUNT);
  localparam int WIRE_W       = 11;
  localparam int WORDS        = 3;
  localparam int WORD_IDX_W   = $clog2(WORDS);
  localparam int WCOUNT_W     = 3;

  // digit alphabet, first symbol in the top byte
  localparam logic [SYMBOL_COUNT*8-1:0] SYMBOL_STR =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()-_=+[]{}<>?";

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    ST_GATE     = 3'd0,
    ST_DONE     = 3'd1,
    ST_WORDS    = 3'd2,
    ST_BADCHAR  = 3'd3,
    ST_UNTERM   = 3'd4,
    ST_TOOLARGE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    K_NEWLINE,
    K_BLANK,
    K_SEMI,
    K_TILDE,
    K_SYMBOL,
    K_BAD
  } char_kind_t;

  typedef struct packed {
    char_kind_t       kind;
    logic             is_hash;
    logic [SYM_W-1:0] sym;
  } char_info_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_beat_t;

  typedef struct packed {
    status_t           status;
    logic [WIRE_W-1:0] wire_target;
    logic [WIRE_W-1:0] wire_ctrl_one;
    logic [WIRE_W-1:0] wire_ctrl_two;
  } gate_beat_t;

  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] idx;
  } sym_hit_t;

  // compare against every symbol of the alphabet, the first match giving the index
  function automatic sym_hit_t symbol_lookup(input logic [7:0] ch);
    sym_hit_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      if (!r.hit && SYMBOL_STR[(SYMBOL_COUNT - 1 - i)*8 +: 8] == ch) begin
        r.hit = 1'b1;
        r.idx = SYM_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ctgp_decode.sv =====
`default_nettype none

module ctgp_decode (
  input  wire logic [7:0]          text_byte,
  output ctgp_pkg::char_info_t     info
);
  import ctgp_pkg::*;

  sym_hit_t lookup;

  always_comb begin
    lookup       = symbol_lookup(text_byte);
    info.sym     = lookup.idx;
    info.is_hash = (text_byte == CH_HASH);
    if (text_byte == CH_LF || text_byte == CH_CR) begin
      info.kind = K_NEWLINE;
    end else if (text_byte == CH_TAB || text_byte == CH_SPACE) begin
      info.kind = K_BLANK;
    end else if (text_byte == CH_SEMI) begin
      info.kind = K_SEMI;
    end else if (text_byte == CH_TILDE) begin
      info.kind = K_TILDE;
    end else if (lookup.hit) begin
      info.kind = K_SYMBOL;
    end else begin
      info.kind = K_BAD;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ctgp_parse.sv =====
`default_nettype none

module ctgp_parse (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 advance,
  input  wire logic                 end_of_text,
  input  wire ctgp_pkg::char_info_t info,
  output logic                      res_valid,
  output ctgp_pkg::gate_beat_t      res
);
  import ctgp_pkg::*;

  logic                in_comment, in_comment_next;
  logic                at_line_start, at_line_start_next;
  logic [TILDE_W-1:0]  tilde_count, tilde_count_next;
  logic [WCOUNT_W-1:0] word_count, word_count_next;
  logic                halted, halted_next;
  logic [WIRE_W-1:0]   word_store [WORDS];
  logic                store_we;
  logic [WIRE_W-1:0]   wire_value;

  // symbol index plus 83 per pending tilde
  assign wire_value = WIRE_W'(info.sym) + WIRE_W'(tilde_count) * WIRE_W'(SYMBOL_COUNT);

  always_comb begin
    in_comment_next    = in_comment;
    at_line_start_next = at_line_start;
    tilde_count_next   = tilde_count;
    word_count_next    = word_count;
    halted_next        = halted;
    store_we           = 1'b0;
    res_valid          = 1'b0;
    res.status         = ST_GATE;
    res.wire_target    = '0;
    res.wire_ctrl_one  = '0;
    res.wire_ctrl_two  = '0;

    if (halted) begin
      // sticky error, beats drain with no result
    end else if (end_of_text) begin
      res_valid = 1'b1;
      if (word_count != '0) begin
        res.status  = ST_UNTERM;
        halted_next = 1'b1;
      end else begin
        res.status         = ST_DONE;
        in_comment_next    = 1'b0;
        at_line_start_next = 1'b1;
        tilde_count_next   = '0;
        word_count_next    = '0;
      end
    end else if (in_comment) begin
      if (info.kind == K_NEWLINE) begin
        in_comment_next    = 1'b0;
        at_line_start_next = 1'b1;
      end
    end else if (at_line_start && info.is_hash) begin
      in_comment_next = 1'b1;
    end else begin
      unique case (info.kind)
        K_SEMI: begin
          tilde_count_next = '0;
          if (word_count == WCOUNT_W'(WORDS)) begin
            res_valid         = 1'b1;
            res.wire_target   = word_store[0];
            res.wire_ctrl_one = word_store[1];
            res.wire_ctrl_two = word_store[2];
            word_count_next   = '0;
          end else if (word_count != '0) begin
            res_valid   = 1'b1;
            res.status  = ST_WORDS;
            halted_next = 1'b1;
          end
        end
        K_TILDE: begin
          if (tilde_count >= TILDE_W'(MAX_TILDES)) begin
            res_valid   = 1'b1;
            res.status  = ST_TOOLARGE;
            halted_next = 1'b1;
          end else begin
            tilde_count_next   = tilde_count + 1'b1;
            at_line_start_next = 1'b0;
          end
        end
        K_NEWLINE: begin
          at_line_start_next = 1'b1;
        end
        K_BLANK: begin
        end
        K_SYMBOL: begin
          if (word_count < WCOUNT_W'(WORDS)) begin
            store_we        = 1'b1;
            word_count_next = word_count + 1'b1;
          end else begin
            word_count_next = WCOUNT_W'(WORDS + 1);
          end
          tilde_count_next   = '0;
          at_line_start_next = 1'b0;
        end
        default: begin
          res_valid   = 1'b1;
          res.status  = ST_BADCHAR;
          halted_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_comment    <= 1'b0;
      at_line_start <= 1'b1;
      tilde_count   <= '0;
      word_count    <= '0;
      halted        <= 1'b0;
    end else if (advance) begin
      in_comment    <= in_comment_next;
      at_line_start <= at_line_start_next;
      tilde_count   <= tilde_count_next;
      word_count    <= word_count_next;
      halted        <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && store_we) begin
      word_store[word_count[WORD_IDX_W-1:0]] <= wire_value;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/circuit_text_gate_parser.sv =====
`default_nettype none

// circuit text gate parser: takes one text character per beat on the text
// channel and gives one beat on the gate channel for each ';' that closes a
// three-word gate (status gate, with the three wire numbers), for the end of
// the text (done, or unterminated if words are pending), and for the first
// error (wrong word count, bad char, wire too large). after an error every
// beat is taken and dropped until reset. a new character is taken every
// cycle unless the held beat has a result while the gate channel is stalled;
// a taken beat sits in the input register, the parse update (lookup plus
// one constant multiply-add) loads its result into the output register,
// and from there the result is offered on the gate channel. the input
// side keeps moving while a result waits on the gate channel as long as
// the beat in the input register gives no result of its own
module circuit_text_gate_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 text_valid,
  output logic                      text_ready,
  input  wire ctgp_pkg::text_beat_t text_beat,
  output logic                      gate_valid,
  input  wire logic                 gate_ready,
  output ctgp_pkg::gate_beat_t      gate_beat
);
  import ctgp_pkg::*;

  // input register
  logic       hold_valid;
  text_beat_t hold_beat;

  // parse step result
  char_info_t info;
  logic       res_valid;
  gate_beat_t res;
  logic       take;
  logic       out_free;

  // the held beat moves on when its result, if any, has room
  assign out_free   = !gate_valid || gate_ready;
  assign take       = hold_valid && (out_free || !res_valid);
  assign text_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (text_valid && text_ready) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && text_ready) begin
      hold_beat <= text_beat;
    end
  end

  ctgp_decode u_decode (
    .text_byte (hold_beat.text_byte),
    .info      (info)
  );

  ctgp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .advance     (take),
    .end_of_text (hold_beat.end_of_text),
    .info        (info),
    .res_valid   (res_valid),
    .res         (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_valid <= 1'b0;
    end else if (take && res_valid) begin
      gate_valid <= 1'b1;
    end else if (gate_ready) begin
      gate_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      gate_beat <= res;
    end
  end

endmodule

`default_nettype wire
